// ===== rtl/bpfa_pkg.sv =====
// Shared types, constants and helpers for the bitmap page frame allocator.
// Used by bpfa_row_unit, the top level and the checker; no dependencies.
package bpfa_pkg;

  // Bitmap geometry: the bitmap is stored as rows of 64 page bits.
  localparam int NUM_PAGES = 4096;
  localparam int MAX_BYTES = NUM_PAGES / 8;
  localparam int ROW_W     = 64;
  localparam int NUM_ROWS  = NUM_PAGES / ROW_W;
  localparam int ROW_AW    = $clog2(NUM_ROWS);
  localparam int BIT_AW    = $clog2(ROW_W);
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int CNT_W     = PAGE_W + 1;
  localparam int BYTES_W   = 10;
  localparam int DATA_W    = 32;
  localparam int CFG_AW    = 3;

  // Operation codes carried in the request tuser field.
  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_TOGGLE = 2'd1,
    FUNC_RUN    = 2'd2,
    FUNC_COUNT  = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // Per-row evaluation returned by the row unit.
  typedef struct packed {
    logic              found;
    logic [BIT_AW-1:0] first_free;
    logic [BIT_AW:0]   free_bits;
    logic [ROW_W-1:0]  wr_data;
  } bpfa_row_res_t;

  // Number of set bits in one byte.
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

endpackage

// ===== rtl/bpfa_row_unit.sv =====
// Combinational evaluation of one bitmap row: free-bit search, free count
// and the modified row to write back. Depends on bpfa_pkg.
module bpfa_row_unit (
  input  bpfa_pkg::func_t              func,
  input  logic [bpfa_pkg::ROW_W-1:0]   row_data,
  input  logic [bpfa_pkg::ROW_W-1:0]   mask,
  output bpfa_pkg::bpfa_row_res_t      res
);

  logic [bpfa_pkg::ROW_W-1:0]  free_v;
  logic [bpfa_pkg::BIT_AW-1:0] idx;
  logic [bpfa_pkg::BIT_AW:0]   cnt;

  // Free pages of the row that lie inside the masked window.
  assign free_v = ~row_data & mask;

  // Lowest free bit of the row.
  always_comb begin
    idx = '0;
    for (int i = bpfa_pkg::ROW_W - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        idx = bpfa_pkg::BIT_AW'(i);
      end
    end
  end

  // Free bit count as a sum of byte counts.
  always_comb begin
    cnt = '0;
    for (int j = 0; j < bpfa_pkg::ROW_W / 8; j++) begin
      cnt = cnt + (bpfa_pkg::BIT_AW + 1)'(bpfa_pkg::popcount8(free_v[8*j +: 8]));
    end
  end

  // Row value to write back for the current operation.
  always_comb begin
    res.found      = |free_v;
    res.first_free = idx;
    res.free_bits  = cnt;
    case (func)
      bpfa_pkg::FUNC_ALLOC: begin
        res.wr_data = row_data | (bpfa_pkg::ROW_W'(1) << idx);
      end
      bpfa_pkg::FUNC_TOGGLE,
      bpfa_pkg::FUNC_RUN: begin
        res.wr_data = row_data ^ mask;
      end
      default: begin
        res.wr_data = row_data;
      end
    endcase
  end

endmodule

// ===== rtl/bitmap_page_frame_allocator_top.sv =====
// Top level of the bitmap page frame allocator: request decode, row memory,
// scan sequencer, result register and configuration port.
// Depends on bpfa_pkg and bpfa_row_unit.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------------
//  in_     | sink      | in_tvalid/in_tready  | tdata: page_index, run_length; tuser: func
//  out_    | source    | out_tvalid/out_tready| tdata: result_page, free_count; tuser: status
//  cfg_    | APB slave | psel/penable/pready  | bitmap_bytes at address 0
//
// One request is processed at a time. The bitmap memory holds 64 pages per row
// and is read and written once per cycle. A request touches all managed rows for
// count, rows up to the first free page for alloc, the rows the run spans for a
// run, one row for a toggle.
// Reset clears every row through per-row valid flags; no clearing pass is run.
// A finished result waits in the output register while the next request is taken.
module bitmap_page_frame_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bpfa_pkg::DATA_W-1:0]   in_tdata,   // [11:0] page_index, [24:12] run_length
  input  logic [1:0]                    in_tuser,   // [1:0] func
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bpfa_pkg::DATA_W-1:0]   out_tdata,  // [11:0] result_page, [24:12] free_count
  output logic [1:0]                    out_tuser,  // [1:0] status
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bpfa_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [bpfa_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [bpfa_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int ROW_AW = bpfa_pkg::ROW_AW;
  localparam int BIT_AW = bpfa_pkg::BIT_AW;
  localparam int PAGE_W = bpfa_pkg::PAGE_W;
  localparam int CNT_W  = bpfa_pkg::CNT_W;
  localparam int ROW_W  = bpfa_pkg::ROW_W;

  // Control and datapath registers.
  bpfa_pkg::state_t    state_r, state_nxt;
  bpfa_pkg::func_t     func_r, func_nxt;
  bpfa_pkg::status_t   res_stat_r, res_stat_nxt, out_stat_r, out_stat_nxt;
  logic [BIT_AW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [ROW_AW-1:0]   rd_row_r, rd_row_nxt, first_row_r, first_row_nxt;
  logic [ROW_AW-1:0]   last_row_r, last_row_nxt, proc_row_r, proc_row_nxt;
  logic                issue_en_r, issue_en_nxt, pend_r, pend_nxt;
  logic [PAGE_W-1:0]   res_page_r, res_page_nxt, out_page_r, out_page_nxt;
  logic [CNT_W-1:0]    res_count_r, res_count_nxt, out_count_r, out_count_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [bpfa_pkg::BYTES_W-1:0] bytes_r;
  logic [bpfa_pkg::NUM_ROWS-1:0] row_valid_r;

  // Bitmap memory, one row of page bits per entry.
  logic [ROW_W-1:0]    mem [bpfa_pkg::NUM_ROWS];
  logic [ROW_W-1:0]    mem_q;
  logic                rv_q;

  // Request fields.
  bpfa_pkg::func_t     in_func;
  logic [PAGE_W-1:0]   in_page;
  logic [CNT_W-1:0]    in_len;
  logic                accept;

  // Range arithmetic done at request acceptance.
  logic [bpfa_pkg::BYTES_W-1:0] bytes_eff;
  logic [CNT_W-1:0]    lim, lim_m1, run_len, run_end, run_last;
  logic [CNT_W:0]      run_sum;
  logic                run_over, run_empty;
  logic                op_empty;
  logic [ROW_AW-1:0]   op_first, op_last;
  logic [BIT_AW-1:0]   op_lo, op_hi;

  // Row processing.
  logic [BIT_AW-1:0]   lo_eff, hi_eff;
  logic [ROW_W-1:0]    row_mask, row_data;
  bpfa_pkg::bpfa_row_res_t rres;
  logic                rd_en, wr_en, scan_end, out_load;
  logic                cfg_wr;

  assign in_func = bpfa_pkg::func_t'(in_tuser);
  assign in_page = in_tdata[PAGE_W-1:0];
  assign in_len  = in_tdata[PAGE_W +: CNT_W];
  assign accept  = in_tvalid && in_tready;

  // Managed page limit and run window.
  always_comb begin
    bytes_eff = (bytes_r > bpfa_pkg::BYTES_W'(bpfa_pkg::MAX_BYTES)) ?
                bpfa_pkg::BYTES_W'(bpfa_pkg::MAX_BYTES) : bytes_r;
    lim       = {bytes_eff, 3'b000};
    lim_m1    = lim - CNT_W'(1);
    run_len   = (in_func == bpfa_pkg::FUNC_TOGGLE) ? CNT_W'(1) : in_len;
    run_sum   = {2'b00, in_page} + {1'b0, run_len};
    run_over  = run_sum > {1'b0, lim};
    run_end   = run_over ? lim : run_sum[CNT_W-1:0];
    run_empty = {1'b0, in_page} >= run_end;
    run_last  = run_end - CNT_W'(1);
    if (in_func == bpfa_pkg::FUNC_ALLOC || in_func == bpfa_pkg::FUNC_COUNT) begin
      op_empty = (lim == '0);
      op_first = '0;
      op_last  = lim_m1[PAGE_W-1:BIT_AW];
      op_lo    = '0;
      op_hi    = lim_m1[BIT_AW-1:0];
    end else begin
      op_empty = run_empty;
      op_first = in_page[PAGE_W-1:BIT_AW];
      op_last  = run_last[PAGE_W-1:BIT_AW];
      op_lo    = in_page[BIT_AW-1:0];
      op_hi    = run_last[BIT_AW-1:0];
    end
  end

  // Bit window of the row under processing.
  always_comb begin
    lo_eff   = (proc_row_r == first_row_r) ? lo_r : '0;
    hi_eff   = (proc_row_r == last_row_r) ? hi_r : BIT_AW'(ROW_W - 1);
    row_mask = ({ROW_W{1'b1}} << lo_eff) & ({ROW_W{1'b1}} >> (BIT_AW'(ROW_W - 1) - hi_eff));
    row_data = rv_q ? mem_q : '0;
  end

  bpfa_row_unit u_row (
    .func     (func_r),
    .row_data (row_data),
    .mask     (row_mask),
    .res      (rres)
  );

  // Scan ends on the last row or on the first free page found by alloc.
  assign scan_end = pend_r &&
                    (proc_row_r == last_row_r ||
                     (func_r == bpfa_pkg::FUNC_ALLOC && rres.found));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpfa_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = op_empty ? bpfa_pkg::S_DONE : bpfa_pkg::S_SCAN;
        end
      end
      bpfa_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = bpfa_pkg::S_DONE;
        end
      end
      bpfa_pkg::S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = bpfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bpfa_pkg::S_IDLE;
      end
    endcase
  end

  // State-driven outputs and memory strobes.
  always_comb begin
    in_tready = (state_r == bpfa_pkg::S_IDLE);
    rd_en     = (state_r == bpfa_pkg::S_SCAN) && issue_en_r;
    wr_en     = (state_r == bpfa_pkg::S_SCAN) && pend_r &&
                (func_r == bpfa_pkg::FUNC_TOGGLE || func_r == bpfa_pkg::FUNC_RUN ||
                 (func_r == bpfa_pkg::FUNC_ALLOC && rres.found));
    out_load  = (state_r == bpfa_pkg::S_DONE) && (!out_tvalid_r || out_tready);
  end

  // Datapath next values.
  always_comb begin
    func_nxt      = func_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    rd_row_nxt    = rd_row_r;
    first_row_nxt = first_row_r;
    last_row_nxt  = last_row_r;
    proc_row_nxt  = proc_row_r;
    issue_en_nxt  = issue_en_r;
    pend_nxt      = pend_r;
    res_page_nxt  = res_page_r;
    res_count_nxt = res_count_r;
    res_stat_nxt  = res_stat_r;
    if (accept) begin
      func_nxt      = in_func;
      lo_nxt        = op_lo;
      hi_nxt        = op_hi;
      rd_row_nxt    = op_first;
      first_row_nxt = op_first;
      last_row_nxt  = op_last;
      issue_en_nxt  = !op_empty;
      pend_nxt      = 1'b0;
      res_page_nxt  = '0;
      res_count_nxt = '0;
      case (in_func)
        bpfa_pkg::FUNC_ALLOC: begin
          res_stat_nxt = bpfa_pkg::STAT_FULL;
        end
        bpfa_pkg::FUNC_TOGGLE,
        bpfa_pkg::FUNC_RUN: begin
          res_stat_nxt = (run_len != '0 && run_over) ? bpfa_pkg::STAT_RANGE
                                                      : bpfa_pkg::STAT_OK;
        end
        default: begin
          res_stat_nxt = bpfa_pkg::STAT_OK;
        end
      endcase
    end
    if (state_r == bpfa_pkg::S_SCAN) begin
      // Issue the next row read while the previous row is processed.
      pend_nxt = issue_en_r;
      if (issue_en_r) begin
        proc_row_nxt = rd_row_r;
        rd_row_nxt   = rd_row_r + ROW_AW'(1);
        if (rd_row_r == last_row_r) begin
          issue_en_nxt = 1'b0;
        end
      end
      if (pend_r) begin
        if (func_r == bpfa_pkg::FUNC_COUNT) begin
          res_count_nxt = res_count_r + CNT_W'(rres.free_bits);
        end
        if (func_r == bpfa_pkg::FUNC_ALLOC && rres.found) begin
          res_page_nxt = {proc_row_r, rres.first_free};
          res_stat_nxt = bpfa_pkg::STAT_OK;
        end
      end
      if (scan_end) begin
        issue_en_nxt = 1'b0;
        pend_nxt     = 1'b0;
      end
    end
  end

  // Output register next values.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_page_nxt   = out_page_r;
    out_count_nxt  = out_count_r;
    out_stat_nxt   = out_stat_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_page_nxt   = res_page_r;
      out_count_nxt  = res_count_r;
      out_stat_nxt   = res_stat_r;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bpfa_pkg::S_IDLE;
      issue_en_r   <= 1'b0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      row_valid_r  <= '0;
      bytes_r      <= bpfa_pkg::BYTES_W'(bpfa_pkg::MAX_BYTES);
    end else begin
      state_r      <= state_nxt;
      issue_en_r   <= issue_en_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (wr_en) begin
        row_valid_r[proc_row_r] <= 1'b1;
      end
      if (cfg_wr) begin
        bytes_r <= cfg_pwdata[bpfa_pkg::BYTES_W-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    rd_row_r    <= rd_row_nxt;
    first_row_r <= first_row_nxt;
    last_row_r  <= last_row_nxt;
    proc_row_r  <= proc_row_nxt;
    res_page_r  <= res_page_nxt;
    res_count_r <= res_count_nxt;
    res_stat_r  <= res_stat_nxt;
    out_page_r  <= out_page_nxt;
    out_count_r <= out_count_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  // Bitmap memory: one read port and one write port, read data registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[proc_row_r] <= rres.wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_row_r];
      rv_q  <= row_valid_r[rd_row_r];
    end
  end

  // Configuration port: one register, word aligned at address zero.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? '0
                                   : {{(bpfa_pkg::DATA_W - bpfa_pkg::BYTES_W){1'b0}}, bytes_r};

  // Result channel.
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(bpfa_pkg::DATA_W - PAGE_W - CNT_W){1'b0}}, out_count_r, out_page_r};
  assign out_tuser  = out_stat_r;

endmodule

// ===== rtl/bpfa_checker.sv =====
// Port-level checks for the bitmap page frame allocator, bound to the top level.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_top.
module bpfa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [bpfa_pkg::DATA_W-1:0] in_tdata,
  input logic [1:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [bpfa_pkg::DATA_W-1:0] out_tdata,
  input logic [1:0]                  out_tuser
);

  // Only one request is in work: the input closes right after a request.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another was in work");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A nonzero page is only reported by a successful alloc.
  a_page_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[bpfa_pkg::PAGE_W-1:0] != '0 |-> out_tuser == bpfa_pkg::STAT_OK)
    else $error("page reported with an error status");

  // A nonzero free count comes from count alone, with no page and no error.
  a_count_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[bpfa_pkg::PAGE_W +: bpfa_pkg::CNT_W] != '0 |->
      out_tdata[bpfa_pkg::PAGE_W-1:0] == '0 && out_tuser == bpfa_pkg::STAT_OK)
    else $error("free count mixed with other result fields");

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker u_bpfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== sim/bpfa_alloc_checker.sv =====
// Checker for the bitmap page frame allocator: keeps its own page bitmap and
// bitmap_bytes copy, predicts each result and compares it field by field.
// Depends on bpfa_pkg; instantiated by tb_bitmap_page_frame_allocator_top.
module bpfa_alloc_checker
  import bpfa_pkg::*;
#(
  parameter logic [CFG_AW-1:0] BYTES_ADDR = '0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,     // [11:0] page_index, [24:12] run_length
  input  logic [1:0]        in_tuser,     // [1:0] func
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [DATA_W-1:0] out_tdata,    // [11:0] result_page, [24:12] free_count
  input  logic [1:0]        out_tuser,    // [1:0] status
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  input  logic [DATA_W-1:0] cfg_prdata,
  input  logic              cfg_pready,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  free_pages;
    status_t           status;
  } page_result_t;

  bit                 frame_used [NUM_PAGES];
  logic [BYTES_W-1:0] bytes_reg;
  page_result_t       pending_results [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t ns mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  // Pages under management; an oversized register saturates at the full bitmap.
  function automatic int managed_limit();
    int b;
    b = (bytes_reg > MAX_BYTES) ? MAX_BYTES : int'(bytes_reg);
    return b * 8;
  endfunction

  // Apply one request to the bitmap copy and return the result it must produce.
  function automatic page_result_t apply_page_op(input func_t op,
                                                 input logic [PAGE_W-1:0] start,
                                                 input logic [CNT_W-1:0] len);
    page_result_t r;
    int           lim;
    int           p;
    int           free_cnt;
    r        = '0;
    lim      = managed_limit();
    free_cnt = 0;
    case (op)
      FUNC_ALLOC: begin
        r.status = STAT_FULL;
        for (p = 0; p < lim && r.status == STAT_FULL; p++) begin
          if (!frame_used[p]) begin
            frame_used[p] = 1'b1;
            r.page        = p[PAGE_W-1:0];
            r.status      = STAT_OK;
          end
        end
      end
      FUNC_TOGGLE: begin
        if (int'(start) < lim) begin
          frame_used[start] = ~frame_used[start];
        end else begin
          r.status = STAT_RANGE;
        end
      end
      FUNC_RUN: begin
        // Pages past the managed range are skipped but flag the request.
        for (int i = 0; i < int'(len); i++) begin
          p = int'(start) + i;
          if (p < lim) begin
            frame_used[p] = ~frame_used[p];
          end else begin
            r.status = STAT_RANGE;
          end
        end
      end
      default: begin
        for (p = 0; p < lim; p++) begin
          if (!frame_used[p]) begin
            free_cnt++;
          end
        end
        r.free_pages = free_cnt[CNT_W-1:0];
      end
    endcase
    return r;
  endfunction

  // Watch the configuration port, the result channel and the request channel.
  always @(posedge clk) begin : watch
    page_result_t want;
    if (!rst_n) begin
      foreach (frame_used[i]) begin
        frame_used[i] = 1'b0;
      end
      bytes_reg = BYTES_W'(MAX_BYTES);
      pending_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == BYTES_ADDR) begin
            bytes_reg = cfg_pwdata[BYTES_W-1:0];
          end
        end else if (cfg_paddr == BYTES_ADDR && cfg_prdata !== DATA_W'(bytes_reg)) begin
          report_mismatch("bitmap_bytes read", bytes_reg, cfg_prdata);
        end
      end

      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding", 0, out_tdata);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[PAGE_W-1:0] !== want.page) begin
            report_mismatch("result_page", want.page, out_tdata[PAGE_W-1:0]);
          end
          if (out_tdata[PAGE_W +: CNT_W] !== want.free_pages) begin
            report_mismatch("free_count", want.free_pages, out_tdata[PAGE_W +: CNT_W]);
          end
          if (out_tuser !== want.status) begin
            report_mismatch("status", want.status, out_tuser);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_page_op(func_t'(in_tuser), in_tdata[PAGE_W-1:0],
                                                in_tdata[PAGE_W +: CNT_W]));
      end
    end
    pending <= pending_results.size();
  end

endmodule

// ===== sim/tb_bitmap_page_frame_allocator_top.sv =====
// Testbench top for the bitmap page frame allocator: clock, reset, request and
// configuration stimulus, result back-pressure and the final verdict.
// Depends on bpfa_pkg, bitmap_page_frame_allocator_top and bpfa_alloc_checker.
module tb_bitmap_page_frame_allocator_top
  import bpfa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] ADDR_BITMAP_BYTES = '0;
  localparam int                PHASES            = 10;
  localparam int                PHASE_REQS        = 125;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata    = '0;   // [11:0] page_index, [24:12] run_length
  logic [1:0]        in_tuser    = '0;   // [1:0] func
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [DATA_W-1:0] out_tdata;          // [11:0] result_page, [24:12] free_count
  logic [1:0]        out_tuser;          // [1:0] status
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  int                errors;
  int                pending;

  // Receiver state: stall countdown, no-stall stretch and the one long hold-off.
  int                hold_left      = 0;
  int                steady_left    = 0;
  int                results_taken  = 0;
  bit                long_hold_done = 1'b0;
  logic              rx_long_hold   = 1'b0;

  always #4 clk = ~clk;

  bitmap_page_frame_allocator_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bpfa_alloc_checker #(
    .BYTES_ADDR (ADDR_BITMAP_BYTES)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .errors      (errors),
    .pending     (pending)
  );

  // Result back-pressure: short and long stalls, no-stall stretches, and one long
  // hold-off after a while so that the block fills up and stalls its input.
  always @(posedge clk) begin : receiver
    int r;
    if (out_tvalid && out_tready) begin
      results_taken <= results_taken + 1;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && results_taken >= 150) begin
      long_hold_done <= 1'b1;
      rx_long_hold   <= 1'b1;
      hold_left      <= 400;
      out_tready     <= 1'b0;
    end else if (steady_left > 0) begin
      steady_left  <= steady_left - 1;
      rx_long_hold <= 1'b0;
      out_tready   <= 1'b1;
    end else begin
      rx_long_hold <= 1'b0;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_tready <= 1'b1;
      end else if (r < 88) begin
        out_tready <= 1'b0;
        hold_left  <= $urandom_range(0, 2);
      end else if (r < 95) begin
        out_tready <= 1'b0;
        hold_left  <= $urandom_range(6, 40);
      end else begin
        out_tready  <= 1'b1;
        steady_left <= $urandom_range(30, 150);
      end
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_req(input func_t op, input logic [PAGE_W-1:0] pg,
                          input logic [CNT_W-1:0] len);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= DATA_W'({len, pg});
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
  endtask

  // Gap between requests: mostly none or short, a few long, none in a steady
  // stretch or while the receiver holds off so that requests keep piling up.
  task automatic idle_gap(input bit steady);
    int r;
    int n;
    n = 0;
    r = $urandom_range(0, 99);
    if (!steady && !rx_long_hold) begin
      if (r >= 90) begin
        n = $urandom_range(5, 40);
      end else if (r >= 60) begin
        n = $urandom_range(1, 3);
      end
    end
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every outstanding request has its result.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // One configuration access: setup cycle, then access cycle until pready.
  task automatic cfg_access(input bit wr, input int value);
    logic [DATA_W-1:0] upper;
    upper       = $urandom;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= ADDR_BITMAP_BYTES;
    cfg_pwdata  <= {upper[DATA_W-1:BYTES_W], value[BYTES_W-1:0]};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) begin
      @(posedge clk);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Random request shaped around the managed page count.
  task automatic random_req(input int lim);
    int    r;
    int    pg;
    int    len;
    func_t op;
    r  = $urandom_range(0, 99);
    op = (r < 35) ? FUNC_ALLOC : (r < 60) ? FUNC_TOGGLE : (r < 80) ? FUNC_RUN : FUNC_COUNT;
    r  = $urandom_range(0, 99);
    if (r < 70 && lim > 0) begin
      pg = $urandom_range(0, lim - 1);
    end else if (r < 88) begin
      pg = $urandom_range(0, NUM_PAGES - 1);
    end else begin
      case ($urandom_range(0, 3))
        0:       pg = 0;
        1:       pg = NUM_PAGES - 1;
        2:       pg = lim - 1;
        default: pg = lim;
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      len = $urandom_range(0, 16);
    end else if (r < 80) begin
      len = $urandom_range(0, 300);
    end else if (r < 95) begin
      len = $urandom_range(0, NUM_PAGES);
    end else begin
      len = ($urandom_range(0, 1) != 0) ? NUM_PAGES : 0;
    end
    send_req(op, PAGE_W'(pg), CNT_W'(len));
  endtask

  function automatic int bytes_for_phase(input int ph);
    case (ph)
      0:       return 1023;
      1:       return 0;
      2:       return 1;
      3:       return 2;
      4:       return MAX_BYTES;
      5:       return $urandom_range(3, 64);
      6:       return MAX_BYTES + 1;
      7:       return $urandom_range(0, 1023);
      8:       return 8;
      default: return MAX_BYTES - 1;
    endcase
  endfunction

  // Main stimulus: directed requests at the reset setting, then random phases.
  initial begin : stimulus
    int value;
    int lim;
    bit steady;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill and empty the whole bitmap, then hit the run and row edges.
    send_req(FUNC_COUNT,  NUM_PAGES - 1, NUM_PAGES);
    send_req(FUNC_RUN,    0,             NUM_PAGES);
    send_req(FUNC_ALLOC,  NUM_PAGES - 1, NUM_PAGES);
    send_req(FUNC_COUNT,  0,             0);
    send_req(FUNC_TOGGLE, NUM_PAGES - 1, 0);
    send_req(FUNC_ALLOC,  0,             0);
    send_req(FUNC_RUN,    0,             NUM_PAGES);
    send_req(FUNC_ALLOC,  0,             0);
    send_req(FUNC_ALLOC,  0,             0);
    send_req(FUNC_TOGGLE, 0,             NUM_PAGES);
    send_req(FUNC_ALLOC,  0,             0);
    send_req(FUNC_RUN,    5,             0);
    send_req(FUNC_RUN,    4000,          200);
    send_req(FUNC_RUN,    NUM_PAGES - 1, NUM_PAGES);
    send_req(FUNC_RUN,    63,            2);
    send_req(FUNC_TOGGLE, 64,            1);
    send_req(FUNC_COUNT,  0,             0);
    send_req(FUNC_ALLOC,  0,             0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      repeat (8) @(posedge clk);
      value = bytes_for_phase(ph);
      lim   = ((value > MAX_BYTES) ? MAX_BYTES : value) * 8;
      cfg_access(1'b1, value);
      cfg_access(1'b0, 0);

      // Edges of the new setting: count, alloc, first page past the end, run across it.
      send_req(FUNC_COUNT,  0,                0);
      send_req(FUNC_ALLOC,  0,                0);
      send_req(FUNC_TOGGLE, PAGE_W'(lim),     0);
      send_req(FUNC_RUN,    PAGE_W'(lim - 1), 2);

      steady = 1'b0;
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n % 25 == 0) begin
          steady = ($urandom_range(0, 3) == 0);
        end
        if (ph == 3 && n == 60) begin
          drain_results();
        end
        random_req(lim);
        idle_gap(steady);
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb_bitmap_page_frame_allocator_top: done, clean");
    end else begin
      $display("tb_bitmap_page_frame_allocator_top: done, errors");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin : watchdog
    #8000000;
    $display("tb_bitmap_page_frame_allocator_top: done, errors");
    $finish;
  end

endmodule
